// ----- design/nlt_pkg.sv -----
// Shared types and constants for the local-threshold binarizer.
// Sequencer state encoding, register indexes, input action codes.
// No dependencies.
`default_nettype none

package nlt_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SUB,
        S_COL_START,
        S_COL_RUN,
        S_PIX,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DEC
    } t_state;

    // Configuration register indexes
    localparam logic [1:0] CFG_K_FACTOR     = 2'd0;
    localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd3;

    // Input action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam int PIX_W  = 8;
    localparam int K_W    = 12;
    localparam int K_FRAC = 8;
    localparam int RAD_W  = 5;
    localparam int DIM_W  = 12;
    localparam int CFG_W  = 12;

endpackage

`default_nettype wire

// ----- design/niblack_local_threshold.sv -----
// Top level of the Niblack local-threshold binarizer.
// Uses nlt_pkg (states, codes) and nlt_ram (line store, column sums).
//
// Usage:
//  - Slave stream: tuser = action (0 pixel, 1 drain), tdata[7:0] = grey level.
//  - Master stream: tdata[0] = pixel_white, tlast = last pixel of the frame.
//  - Config port: i_cfg_we / i_cfg_addr / i_cfg_wdata; 0 k_factor, 1 radius,
//    2 width, 3 height. Any write restarts the frame. Write only when idle.
//  - Pixels go in raster order; each pixel is stored in a line store of
//    2*MAX_RADIUS+2 rows. Outputs trail the input until their clipped window
//    has arrived; after the last pixel, send drain transactions to flush.
//  - Timing: the sequencer handles one transaction at a time. An item that
//    stores nothing leaves it in idle; a stored pixel whose output is not
//    ready goes through the check step and back. An item with a result runs
//    check, a subtract step when a column leaves the window, a column read
//    when one enters it (yc = window rows, at most 2*r+1, read from the line
//    store one row per cycle), then pixel, the multiply steps and the decision.
//    A new output row builds its window column by column, c = min(r, width-1) + 1 columns.
//  - Threshold test is exact: squared comparison, no square root.
//  - Reset: counters and window sums clear; registers take defaults
//    (k=0, r=20, 2048x2048). The memories need no clearing.
//  - A stalled receiver holds the result in the output register; the
//    sequencer waits in its final step until the register frees up.
`default_nettype none

module niblack_local_threshold
    import nlt_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_RADIUS = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // tdata: [7:0] pixel_value
    input  wire logic [7:0]       s_axis_tdata,
    // tuser: [0] action
    input  wire logic             s_axis_tuser,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: [0] pixel_white, [7:1] zero
    output logic [7:0]            m_axis_tdata,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W   = $clog2(STORE_ROWS);
    localparam int XW       = $clog2(MAX_WIDTH);
    localparam int YW       = $clog2(MAX_HEIGHT);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int LS_DEPTH = STORE_ROWS * MAX_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int RW       = $clog2(MAX_RADIUS + 1);
    localparam int SPAN     = 2 * MAX_RADIUS + 1;
    localparam int SPAN_W   = $clog2(SPAN + 1);
    localparam int CS_W     = $clog2(SPAN * 255 + 1);
    localparam int CQ_W     = $clog2(SPAN * 65025 + 1);
    localparam int WS_W     = $clog2(SPAN * SPAN * 255 + 1);
    localparam int WQ_W     = $clog2(SPAN * SPAN * 65025 + 1);
    localparam int N_W      = $clog2(SPAN * SPAN + 1);
    localparam int NP_W     = N_W + PIX_W;
    localparam int D_W      = ((NP_W > WS_W) ? NP_W : WS_W) + 1;
    localparam int NQ_W     = N_W + WQ_W;
    localparam int SS_W     = 2 * WS_W;
    localparam int S_W      = NQ_W;
    localparam int SL_W     = (S_W + 1) / 2;
    localparam int SH_W     = S_W - SL_W;
    localparam int KK_W     = 2 * K_W;
    localparam int DD_W     = 2 * (D_W - 1);
    localparam int KS_W     = KK_W + S_W;
    localparam int DX_W     = DD_W + 2 * K_FRAC;
    localparam int CMP_W    = ((KS_W > DX_W) ? KS_W : DX_W) + 1;
    localparam int CR_W     = CS_W + CQ_W;

    t_state r_state, n_state;

    // configuration
    logic signed [K_W-1:0]   r_k;
    logic [RAD_W-1:0]        r_rad;
    logic [DIM_W-1:0]        r_w;
    logic [DIM_W-1:0]        r_h;

    // input and output positions
    logic [XW-1:0]     r_in_col;
    logic [YW-1:0]     r_in_row;
    logic [SLOT_W-1:0] r_in_slot;
    logic              r_in_done;
    logic [XW-1:0]     r_ox;
    logic [YW-1:0]     r_oy;
    logic [SLOT_W-1:0] r_oy_slot;

    // window state
    logic [WS_W-1:0]   r_ws;
    logic [WQ_W-1:0]   r_wq;
    logic [XW-1:0]     r_need_col;
    logic [SPAN_W-1:0] r_xc;
    logic [SPAN_W-1:0] r_yc;
    logic [SLOT_W-1:0] r_y0_slot;
    logic              r_add_en;
    logic [XW-1:0]     r_col;
    logic [SPAN_W-1:0] r_rows_left;
    logic [SLOT_W-1:0] r_rslot;
    logic              r_rdv;
    logic [CS_W-1:0]   r_cs;
    logic [CQ_W-1:0]   r_cq;

    // decision datapath
    logic [N_W-1:0]        r_n;
    logic signed [D_W-1:0] r_d;
    logic [NQ_W-1:0]       r_nq;
    logic [SS_W-1:0]       r_ss;
    logic [KK_W-1:0]       r_kk;
    logic [S_W-1:0]        r_s;
    logic [DD_W-1:0]       r_dd;
    logic [KK_W+SL_W-1:0]  r_ks_lo;
    logic [KK_W+SH_W-1:0]  r_ks_hi;

    // output register
    logic r_out_valid;
    logic r_out_white;
    logic r_out_last;

    // effective sizes
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [RW-1:0] rad;
    logic [XW-1:0] w_last;
    logic [YW-1:0] h_last;

    always_comb begin
        if (r_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_w) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_w);
        end
        if (r_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_h) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_h);
        end
        if (32'(r_rad) > MAX_RADIUS) begin
            rad = RW'(MAX_RADIUS);
        end else begin
            rad = RW'(r_rad);
        end
        w_last = XW'(w_eff - WW'(1));
        h_last = YW'(h_eff - HW'(1));
    end

    function automatic logic [LS_AW-1:0] ls_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [XW-1:0] col);
        ls_addr = LS_AW'(32'(slot) * MAX_WIDTH + 32'(col));
    endfunction

    // window geometry of the current output position
    logic [WW:0]       ox_pr;
    logic [HW:0]       oy_pr;
    logic              col_in;
    logic              row_in;
    logic [XW-1:0]     need_col;
    logic [YW-1:0]     need_row;
    logic [XW-1:0]     x0;
    logic [YW-1:0]     y0;
    logic [RW-1:0]     rmin;
    logic [SLOT_W-1:0] y0_slot;
    logic              ready;
    logic              sub_en;
    logic              last_pos;

    always_comb begin
        ox_pr    = (WW+1)'(r_ox) + (WW+1)'(rad);
        oy_pr    = (HW+1)'(r_oy) + (HW+1)'(rad);
        col_in   = ox_pr < (WW+1)'(w_eff);
        row_in   = oy_pr < (HW+1)'(h_eff);
        need_col = col_in ? XW'(ox_pr) : w_last;
        need_row = row_in ? YW'(oy_pr) : h_last;
        x0       = (r_ox > XW'(rad)) ? (r_ox - XW'(rad)) : '0;
        y0       = (r_oy > YW'(rad)) ? (r_oy - YW'(rad)) : '0;
        rmin     = (r_oy > YW'(rad)) ? rad : RW'(r_oy);
        if (32'(r_oy_slot) >= 32'(rmin)) begin
            y0_slot = SLOT_W'(32'(r_oy_slot) - 32'(rmin));
        end else begin
            y0_slot = SLOT_W'(32'(r_oy_slot) + STORE_ROWS - 32'(rmin));
        end
        ready    = r_in_done || (r_in_row > need_row) ||
                   (r_in_row == need_row && r_in_col > need_col);
        sub_en   = r_ox > XW'(rad);
        last_pos = (r_ox == w_last) && (r_oy == h_last);
    end

    // memories
    logic              ls_we;
    logic [LS_AW-1:0]  ls_waddr;
    logic [LS_AW-1:0]  ls_raddr;
    logic [PIX_W-1:0]  ls_rdata;
    logic              cr_we;
    logic [XW-1:0]     cr_waddr;
    logic [XW-1:0]     cr_raddr;
    logic [CR_W-1:0]   cr_rdata;

    nlt_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ls_we),
        .i_waddr (ls_waddr),
        .i_wdata (s_axis_tdata[PIX_W-1:0]),
        .i_raddr (ls_raddr),
        .o_rdata (ls_rdata)
    );

    nlt_ram #(.WIDTH(CR_W), .DEPTH(MAX_WIDTH)) u_column_store (
        .i_clk   (i_clk),
        .i_we    (cr_we),
        .i_waddr (cr_waddr),
        .i_wdata ({r_cq, r_cs}),
        .i_raddr (cr_raddr),
        .o_rdata (cr_rdata)
    );

    logic s_acc;
    logic store_px;
    logic out_free;
    logic col_done;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign store_px  = s_acc && (s_axis_tuser == ACT_PIXEL) && !r_in_done;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign col_done  = (r_rows_left == '0) && !r_rdv;

    // next state and memory control
    always_comb begin
        n_state  = r_state;
        ls_we    = store_px;
        ls_waddr = ls_addr(r_in_slot, r_in_col);
        ls_raddr = ls_addr(r_rslot, r_col);
        cr_we    = 1'b0;
        cr_waddr = r_col;
        cr_raddr = XW'(r_ox - XW'(rad) - XW'(1));
        unique case (r_state)
            S_IDLE: begin
                if (store_px || (s_acc && s_axis_tuser == ACT_DRAIN && r_in_done)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!ready) begin
                    n_state = S_IDLE;
                end else if (r_ox == '0) begin
                    n_state = S_COL_START;
                end else if (sub_en) begin
                    n_state = S_SUB;
                end else if (col_in) begin
                    n_state = S_COL_START;
                end else begin
                    n_state = S_PIX;
                end
            end
            S_SUB: begin
                n_state = r_add_en ? S_COL_START : S_PIX;
            end
            S_COL_START: begin
                n_state = S_COL_RUN;
            end
            S_COL_RUN: begin
                if (col_done) begin
                    cr_we = 1'b1;
                    if (r_ox == '0 && r_col != r_need_col) begin
                        n_state = S_COL_START;
                    end else begin
                        n_state = S_PIX;
                    end
                end
            end
            S_PIX: begin
                ls_raddr = ls_addr(r_oy_slot, r_ox);
                n_state  = S_MUL1;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_DEC;
            S_DEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // decision terms
    logic [NP_W-1:0]         np;
    logic [D_W-2:0]          d_abs;
    logic [CMP_W-1:0]        ks;
    logic [CMP_W-1:0]        ddx;
    logic                    black;
    logic signed [KK_W-1:0]  kk_s;

    always_comb begin
        np    = NP_W'(r_n) * NP_W'(ls_rdata);
        d_abs = (r_d < 0) ? (D_W-1)'(-r_d) : (D_W-1)'(r_d);
        kk_s  = KK_W'(r_k) * KK_W'(r_k);
        ks    = (CMP_W'(r_ks_hi) << SL_W) + CMP_W'(r_ks_lo);
        ddx   = CMP_W'(r_dd) << (2 * K_FRAC);
        if (r_k < 0) begin
            black = (r_d < 0) || (ddx < ks);
        end else begin
            black = (r_d < 0) && (ddx > ks);
        end
    end

    // control and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_rad       <= RAD_W'(20);
            r_w         <= DIM_W'(2048);
            r_h         <= DIM_W'(2048);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_slot   <= '0;
            r_in_done   <= 1'b0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_oy_slot   <= '0;
            r_ws        <= '0;
            r_wq        <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_K_FACTOR:      r_k   <= K_W'(i_cfg_wdata);
                CFG_WINDOW_RADIUS: r_rad <= RAD_W'(i_cfg_wdata);
                CFG_IMAGE_WIDTH:   r_w   <= DIM_W'(i_cfg_wdata);
                CFG_IMAGE_HEIGHT:  r_h   <= DIM_W'(i_cfg_wdata);
                default:           r_k   <= r_k;
            endcase
            // restart the frame
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_slot <= '0;
            r_in_done <= 1'b0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_oy_slot <= '0;
            r_ws      <= '0;
            r_wq      <= '0;
        end else begin
            // the final step reloads the output register itself
            if (m_axis_tready && r_state != S_DEC) begin
                r_out_valid <= 1'b0;
            end
            // advance the input position
            if (store_px) begin
                if (r_in_col == w_last) begin
                    r_in_col <= '0;
                    if (r_in_row == h_last) begin
                        r_in_row  <= '0;
                        r_in_slot <= '0;
                        r_in_done <= 1'b1;
                    end else begin
                        r_in_row  <= r_in_row + YW'(1);
                        r_in_slot <= (r_in_slot == SLOT_W'(STORE_ROWS - 1)) ?
                                     '0 : r_in_slot + SLOT_W'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + XW'(1);
                end
            end
            case (r_state)
                S_CHECK: begin
                    if (ready && r_ox == '0) begin
                        r_ws <= '0;
                        r_wq <= '0;
                    end
                end
                S_SUB: begin
                    r_ws <= r_ws - WS_W'(cr_rdata[CS_W-1:0]);
                    r_wq <= r_wq - WQ_W'(cr_rdata[CR_W-1:CS_W]);
                end
                S_COL_RUN: begin
                    if (col_done) begin
                        r_ws <= r_ws + WS_W'(r_cs);
                        r_wq <= r_wq + WQ_W'(r_cq);
                    end
                end
                S_DEC: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_white <= !black;
                        r_out_last  <= last_pos;
                        if (last_pos) begin
                            // frame done: back to the top
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_in_slot <= '0;
                            r_in_done <= 1'b0;
                            r_ox      <= '0;
                            r_oy      <= '0;
                            r_oy_slot <= '0;
                            r_ws      <= '0;
                            r_wq      <= '0;
                        end else if (r_ox == w_last) begin
                            r_ox      <= '0;
                            r_oy      <= r_oy + YW'(1);
                            r_oy_slot <= (r_oy_slot == SLOT_W'(STORE_ROWS - 1)) ?
                                         '0 : r_oy_slot + SLOT_W'(1);
                        end else begin
                            r_ox <= r_ox + XW'(1);
                        end
                    end
                end
                default: begin
                    r_ws <= r_ws;
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_CHECK: begin
                r_need_col <= need_col;
                r_xc       <= SPAN_W'(need_col - x0 + XW'(1));
                r_yc       <= SPAN_W'(need_row - y0 + YW'(1));
                r_y0_slot  <= y0_slot;
                r_add_en   <= col_in;
                r_col      <= (r_ox == '0) ? '0 : XW'(ox_pr);
            end
            S_COL_START: begin
                r_rows_left <= r_yc;
                r_rslot     <= r_y0_slot;
                r_rdv       <= 1'b0;
                r_cs        <= '0;
                r_cq        <= '0;
            end
            S_COL_RUN: begin
                // issue one row read per cycle, accumulate in the next cycle
                if (r_rows_left != '0) begin
                    r_rows_left <= r_rows_left - SPAN_W'(1);
                    r_rslot     <= (r_rslot == SLOT_W'(STORE_ROWS - 1)) ?
                                   '0 : r_rslot + SLOT_W'(1);
                end
                r_rdv <= (r_rows_left != '0);
                if (r_rdv) begin
                    r_cs <= r_cs + CS_W'(ls_rdata);
                    r_cq <= r_cq + CQ_W'(16'(ls_rdata) * 16'(ls_rdata));
                end
                if (col_done) begin
                    r_col <= r_col + XW'(1);
                end
            end
            S_PIX: begin
                r_n <= N_W'(N_W'(r_xc) * N_W'(r_yc));
            end
            S_MUL1: begin
                r_d  <= $signed(D_W'(np)) - $signed(D_W'(r_ws));
                r_nq <= NQ_W'(r_n) * NQ_W'(r_wq);
                r_ss <= SS_W'(r_ws) * SS_W'(r_ws);
                r_kk <= KK_W'(kk_s);
            end
            S_MUL2: begin
                r_s  <= S_W'(r_nq - NQ_W'(r_ss));
                r_dd <= DD_W'(d_abs) * DD_W'(d_abs);
            end
            S_MUL3: begin
                r_ks_lo <= (KK_W+SL_W)'(r_kk) * (KK_W+SL_W)'(r_s[SL_W-1:0]);
                r_ks_hi <= (KK_W+SH_W)'(r_kk) * (KK_W+SH_W)'(r_s[S_W-1:SL_W]);
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_white};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- design/nlt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module nlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
